// ===== design/per_layer_slot_allocator_unit_defines.svh =====
// -----------------------------------------------------------------------------
// per_layer_slot_allocator_unit_defines.svh
// Assertion macros used by the slot allocator top-level RTL.
// -----------------------------------------------------------------------------
`ifndef PER_LAYER_SLOT_ALLOCATOR_UNIT_DEFINES_SVH
`define PER_LAYER_SLOT_ALLOCATOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define PSLOT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slot allocator assertion failed");

// next-cycle implication
`define PSLOT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slot allocator assertion failed");

`else

`define PSLOT_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define PSLOT_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/pslot_pkg.sv =====
// -----------------------------------------------------------------------------
// pslot_pkg
// Constants, types and codes of the per-layer slot allocator.
// -----------------------------------------------------------------------------
`default_nettype none

package pslot_pkg;

    localparam int LAYERS      = 64;
    localparam int EXPERT_BITS = 8;
    localparam int MAX_SLOTS   = 256;

    localparam int KEY_W      = 16;
    localparam int LAYER_W    = KEY_W - EXPERT_BITS;
    localparam int ROW_W      = $clog2(LAYERS);
    localparam int SLOT_W     = 8;
    localparam int SIDX_W     = $clog2(MAX_SLOTS);
    localparam int CNT_W      = $clog2(MAX_SLOTS + 1);
    localparam int MAP_AW     = ROW_W + EXPERT_BITS;
    localparam int STK_AW     = ROW_W + SIDX_W;
    localparam int QUOTA_W    = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 9;
    localparam int QDEPTH     = 2;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        ACT_LOOKUP  = 2'd0,
        ACT_ALLOC   = 2'd1,
        ACT_RELEASE = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_RANGE   = 2'd2
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_LAYER   = 3'd0,
        CFG_LAYER_QUOTA  = 3'd1,
        CFG_PIN_ENABLE   = 3'd2,
        CFG_PIN_LOW      = 3'd3,
        CFG_PIN_HIGH     = 3'd4,
        CFG_EXPERT_COUNT = 3'd5
    } cfg_idx_t;

    typedef enum logic [2:0] {
        B_CLEAR,
        B_IDLE,
        B_EVAL,
        B_POP,
        B_DONE
    } back_state_t;

    // classified request, front to back
    typedef struct packed {
        action_t                  act;
        logic                     in_range;
        logic [ROW_W-1:0]         row;
        logic [EXPERT_BITS-1:0]   expert;
        logic [QUOTA_W-1:0]       quota;
    } qentry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    typedef struct packed {
        logic clearing;
    } bstat_t;

    typedef struct packed {
        logic              valid;
        logic [SLOT_W-1:0] slot;
    } mapent_t;

    typedef struct packed {
        logic [CNT_W-1:0] depth;
        logic [CNT_W-1:0] fresh;
    } rowstate_t;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic              present;
        status_t           status;
    } result_t;

endpackage

`default_nettype wire

// ===== design/pslot_req_if.sv =====
// -----------------------------------------------------------------------------
// pslot_req_if
// Request channel: action and key.
// -----------------------------------------------------------------------------
`default_nettype none

interface pslot_req_if
    import pslot_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [1:0]       action;
    logic [KEY_W-1:0] key;

    modport source (output valid, output action, output key, input ready);
    modport sink   (input valid, input action, input key, output ready);
endinterface

`default_nettype wire

// ===== design/pslot_rsp_if.sv =====
// -----------------------------------------------------------------------------
// pslot_rsp_if
// Response channel: slot, present flag and status.
// -----------------------------------------------------------------------------
`default_nettype none

interface pslot_rsp_if
    import pslot_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [SLOT_W-1:0] slot;
    logic              present;
    logic [1:0]        status;

    modport source (output valid, output slot, output present, output status, input ready);
    modport sink   (input valid, input slot, input present, input status, output ready);
endinterface

`default_nettype wire

// ===== design/pslot_cfg_if.sv =====
// -----------------------------------------------------------------------------
// pslot_cfg_if
// Configuration write channel: register index and write data.
// -----------------------------------------------------------------------------
`default_nettype none

interface pslot_cfg_if
    import pslot_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/pslot_front.sv =====
// -----------------------------------------------------------------------------
// pslot_front
// Config registers; accepts requests, resolves row, range and quota.
// -----------------------------------------------------------------------------
`default_nettype none

module pslot_front
    import pslot_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    pslot_req_if.sink  req,
    pslot_cfg_if.sink  cfg,
    input  bstat_t     bstat,
    input  qstat_t     qstat,
    output logic       push,
    output qentry_t    push_data
);

    logic [LAYER_W-1:0] base_layer_reg;
    logic [QUOTA_W-1:0] layer_quota_reg;
    logic               pin_enable_reg;
    logic [LAYER_W-1:0] pin_low_reg;
    logic [LAYER_W-1:0] pin_high_reg;
    logic [QUOTA_W-1:0] expert_count_reg;

    logic [LAYER_W-1:0] layer;
    logic [LAYER_W-1:0] diff;
    logic               pinned;
    logic [QUOTA_W-1:0] quota_raw;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_layer_reg   <= '0;
            layer_quota_reg  <= QUOTA_W'(256);
            pin_enable_reg   <= 1'b0;
            pin_low_reg      <= '0;
            pin_high_reg     <= '0;
            expert_count_reg <= QUOTA_W'(256);
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_idx_t'(cfg.index))
                CFG_BASE_LAYER:   base_layer_reg   <= cfg.data[LAYER_W-1:0];
                CFG_LAYER_QUOTA:  layer_quota_reg  <= cfg.data[QUOTA_W-1:0];
                CFG_PIN_ENABLE:   pin_enable_reg   <= cfg.data[0];
                CFG_PIN_LOW:      pin_low_reg      <= cfg.data[LAYER_W-1:0];
                CFG_PIN_HIGH:     pin_high_reg     <= cfg.data[LAYER_W-1:0];
                CFG_EXPERT_COUNT: expert_count_reg <= cfg.data[QUOTA_W-1:0];
                default:          ;  // unknown index ignored
            endcase
        end
    end

    always_comb
    begin
        layer  = req.key[KEY_W-1:EXPERT_BITS];
        diff   = layer - base_layer_reg;
        pinned = (layer >= pin_low_reg) && (layer <= pin_high_reg);
        if (pin_enable_reg)
            quota_raw = pinned ? expert_count_reg : '0;
        else
            quota_raw = layer_quota_reg;

        push_data.act      = action_t'(req.action);
        push_data.in_range = (layer >= base_layer_reg)
                          && ({1'b0, diff} < (LAYER_W + 1)'(LAYERS));
        push_data.row      = diff[ROW_W-1:0];
        push_data.expert   = req.key[EXPERT_BITS-1:0];
        push_data.quota    = (quota_raw > QUOTA_W'(MAX_SLOTS)) ? QUOTA_W'(MAX_SLOTS)
                                                               : quota_raw;
    end

    assign req.ready = !qstat.full && !bstat.clearing;
    assign push      = req.valid && req.ready;

endmodule

`default_nettype wire

// ===== design/pslot_queue.sv =====
// -----------------------------------------------------------------------------
// pslot_queue
// Short FIFO of classified requests between front and back.
// -----------------------------------------------------------------------------
`default_nettype none

module pslot_queue
    import pslot_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  qentry_t push_data,
    input  logic    pop,
    output qentry_t pop_data,
    output qstat_t  qstat
);

    qentry_t            ent_reg [QDEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            ent_reg[wr_ptr_reg] <= push_data;
    end

    assign pop_data    = ent_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign qstat.empty = (count_reg == '0);

endmodule

`default_nettype wire

// ===== design/pslot_back.sv =====
// -----------------------------------------------------------------------------
// pslot_back
// Executes requests: slot map, row counters and freed-slot stacks.
// -----------------------------------------------------------------------------
`default_nettype none

module pslot_back
    import pslot_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  qstat_t       qstat,
    input  qentry_t      pop_data,
    output logic         pop,
    output bstat_t       bstat,
    pslot_rsp_if.source  rsp
);

    back_state_t        state_reg, state_next;
    logic [MAP_AW-1:0]  clr_reg, clr_next;
    logic               out_valid_reg, out_valid_next;
    qentry_t            work_reg, work_next;
    result_t            res_reg, res_next;
    result_t            out_reg, out_next;

    // storage
    mapent_t            map_mem [1 << MAP_AW];
    rowstate_t          row_mem [LAYERS];
    logic [SLOT_W-1:0]  stk_mem [1 << STK_AW];

    mapent_t            map_rd_reg;
    rowstate_t          row_rd_reg;
    logic [SLOT_W-1:0]  stk_rd_reg;

    logic               map_we, map_re;
    logic [MAP_AW-1:0]  map_waddr, map_raddr;
    mapent_t            map_wdata;
    logic               row_we, row_re;
    logic [ROW_W-1:0]   row_waddr, row_raddr;
    rowstate_t          row_wdata;
    logic               stk_we, stk_re;
    logic [STK_AW-1:0]  stk_waddr, stk_raddr;
    logic [SLOT_W-1:0]  stk_wdata;
    logic [CNT_W-1:0]   depth_dec;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        work_next      = work_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        pop            = 1'b0;

        map_we    = 1'b0;
        map_re    = 1'b0;
        map_waddr = {work_reg.row, work_reg.expert};
        map_raddr = {pop_data.row, pop_data.expert};
        map_wdata = '0;
        row_we    = 1'b0;
        row_re    = 1'b0;
        row_waddr = work_reg.row;
        row_raddr = pop_data.row;
        row_wdata = row_rd_reg;
        stk_we    = 1'b0;
        stk_re    = 1'b0;
        stk_waddr = {work_reg.row, row_rd_reg.depth[SIDX_W-1:0]};
        stk_wdata = map_rd_reg.slot;
        depth_dec = CNT_W'(row_rd_reg.depth - 1'b1);
        stk_raddr = {work_reg.row, depth_dec[SIDX_W-1:0]};

        unique case (state_reg)
            B_CLEAR:
            begin
                // one map entry per cycle; row counters are cleared alongside the first LAYERS map entries
                map_we    = 1'b1;
                map_waddr = clr_reg;
                map_wdata = '0;
                if (clr_reg < MAP_AW'(LAYERS))
                begin
                    row_we    = 1'b1;
                    row_waddr = clr_reg[ROW_W-1:0];
                    row_wdata = '0;
                end
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                    state_next = B_IDLE;
            end

            B_IDLE:
            begin
                if (!qstat.empty)
                begin
                    pop        = 1'b1;
                    work_next  = pop_data;
                    map_re     = 1'b1;
                    row_re     = 1'b1;
                    state_next = B_EVAL;
                end
            end

            B_EVAL:
            begin
                state_next = B_DONE;
                if (!work_reg.in_range)
                begin
                    res_next = '{slot: '0, present: 1'b0, status: ST_RANGE};
                end
                else
                begin
                    unique case (work_reg.act)
                        ACT_ALLOC:
                        begin
                            if (row_rd_reg.depth != '0)
                            begin
                                // reuse most recently freed slot
                                row_we          = 1'b1;
                                row_wdata.depth = depth_dec;
                                stk_re          = 1'b1;
                                state_next      = B_POP;
                            end
                            else if (row_rd_reg.fresh < CNT_W'(work_reg.quota))
                            begin
                                row_we          = 1'b1;
                                row_wdata.fresh = CNT_W'(row_rd_reg.fresh + 1'b1);
                                map_we          = 1'b1;
                                map_wdata       = '{valid: 1'b1,
                                                    slot: row_rd_reg.fresh[SLOT_W-1:0]};
                                res_next        = '{slot: row_rd_reg.fresh[SLOT_W-1:0],
                                                    present: 1'b1, status: ST_OK};
                            end
                            else
                            begin
                                res_next = '{slot: map_rd_reg.valid ? map_rd_reg.slot : '0,
                                             present: map_rd_reg.valid,
                                             status: ST_NO_FREE};
                            end
                        end

                        ACT_RELEASE:
                        begin
                            if (map_rd_reg.valid)
                            begin
                                map_we    = 1'b1;
                                map_wdata = '0;
                                if (row_rd_reg.depth < CNT_W'(MAX_SLOTS))
                                begin
                                    stk_we          = 1'b1;
                                    row_we          = 1'b1;
                                    row_wdata.depth = CNT_W'(row_rd_reg.depth + 1'b1);
                                end
                                res_next = '{slot: map_rd_reg.slot, present: 1'b1,
                                             status: ST_OK};
                            end
                            else
                            begin
                                res_next = '{slot: '0, present: 1'b0, status: ST_OK};
                            end
                        end

                        default:  // lookup; unused action code too
                        begin
                            res_next = '{slot: map_rd_reg.valid ? map_rd_reg.slot : '0,
                                         present: map_rd_reg.valid, status: ST_OK};
                        end
                    endcase
                end
            end

            B_POP:
            begin
                map_we     = 1'b1;
                map_wdata  = '{valid: 1'b1, slot: stk_rd_reg};
                res_next   = '{slot: stk_rd_reg, present: 1'b1, status: ST_OK};
                state_next = B_DONE;
            end

            B_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = B_IDLE;
                end
            end

            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg <= work_next;
        res_reg  <= res_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[map_waddr] <= map_wdata;
        if (map_re)
            map_rd_reg <= map_mem[map_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
            row_mem[row_waddr] <= row_wdata;
        if (row_re)
            row_rd_reg <= row_mem[row_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
            stk_mem[stk_waddr] <= stk_wdata;
        if (stk_re)
            stk_rd_reg <= stk_mem[stk_raddr];
    end

    assign bstat.clearing = (state_reg == B_CLEAR);

    assign rsp.valid   = out_valid_reg;
    assign rsp.slot    = out_reg.slot;
    assign rsp.present = out_reg.present;
    assign rsp.status  = out_reg.status;

endmodule

`default_nettype wire

// ===== design/per_layer_slot_allocator_unit.sv =====
// Flow: the back end reads the map entry and row counters (B_IDLE), decides and
//   writes back (B_EVAL), reads the freed-slot stack when an allocate reuses
//   a freed slot (B_POP), and registers the response (B_DONE). It takes one
//   request at a time, the next once the response register is free.
// Reset: a clearing pass sweeps the 16384 slot map entries and row counters;
//   no requests are taken meanwhile, config writes are.
// -----------------------------------------------------------------------------
// per_layer_slot_allocator_unit
// Per-layer free-list slot allocator: lookup, allocate and release of slots
// keyed by layer and expert number.
// -----------------------------------------------------------------------------
`default_nettype none

`include "per_layer_slot_allocator_unit_defines.svh"

module per_layer_slot_allocator_unit
    import pslot_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    pslot_cfg_if.sink    cfg,
    pslot_req_if.sink    req,
    pslot_rsp_if.source  rsp
);

    // front -> queue
    logic    push;
    qentry_t push_data;

    // queue -> back
    logic    pop;
    qentry_t pop_data;
    qstat_t  qstat;

    // back -> front: hold off requests during the clearing pass
    bstat_t  bstat;

    // Front end: register file plus request classification. The layer is
    // turned into a table row, checked against the window of LAYERS rows
    // starting at base_layer, and the quota (pinned or uniform, capped at
    // MAX_SLOTS) is resolved here so the back end never sees the config.
    pslot_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg       (cfg),
        .bstat     (bstat),
        .qstat     (qstat),
        .push      (push),
        .push_data (push_data)
    );

    // Two-entry queue decouples the request side from the back end.
    pslot_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .qstat     (qstat)
    );

    // Back end: one request at a time. Reads map entry and row counters,
    // decides, writes back, and (for freed-slot reuse) reads the stack top.
    // The result sits in an output register so the next request can start
    // while the response waits for the sink.
    pslot_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .qstat    (qstat),
        .pop_data (pop_data),
        .pop      (pop),
        .bstat    (bstat),
        .rsp      (rsp)
    );

    // back end never pops an empty queue
    `PSLOT_ASSERT_IMPLIES(a_pop_not_empty, clk, rst_n, pop, !qstat.empty)
    // no request transaction during the clearing pass
    `PSLOT_ASSERT_IMPLIES(a_no_req_clearing, clk, rst_n, req.valid && req.ready, !bstat.clearing)
    // no response can exist before the clearing pass is over
    `PSLOT_ASSERT_IMPLIES(a_no_rsp_clearing, clk, rst_n, bstat.clearing, !rsp.valid)
    // a pushed request is visible to the back end next cycle
    `PSLOT_ASSERT_NEXT(a_push_lands, clk, rst_n, push, !qstat.empty)

endmodule

`default_nettype wire
